FILE: rtl/b64u_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64u_pkg
// Shared types, codes and the sextet-to-character map of the base64url encoder.
// ----------------------------------------------------------------------------
package b64u_pkg;

	// position of a byte within its three-byte group
	typedef enum logic [2:0] {
		PH_FIRST  = 3'b001,
		PH_SECOND = 3'b010,
		PH_THIRD  = 3'b100
	} group_phase_t;

	// one classified word handed from front to back
	typedef struct packed {
		logic [5:0] sext_a;  // always emitted
		logic [5:0] sext_b;  // emitted when pair is set
		logic       pair;    // two characters for this byte
		logic       last;    // message ends with this byte
	} entry_t;

	// sextet ranges of the alphabet
	localparam logic [5:0] SEXT_LOWER_START = 6'd26;
	localparam logic [5:0] SEXT_DIGIT_START = 6'd52;
	localparam logic [5:0] SEXT_DASH        = 6'd62;
	localparam logic [5:0] SEXT_UNDERSCORE  = 6'd63;

	// ascii codes
	localparam logic [6:0] CHAR_UPPER_A    = 7'h41;
	localparam logic [6:0] CHAR_LOWER_A    = 7'h61;
	localparam logic [6:0] CHAR_DIGIT_0    = 7'h30;
	localparam logic [6:0] CHAR_DASH       = 7'h2D;
	localparam logic [6:0] CHAR_UNDERSCORE = 7'h5F;

	function automatic logic [6:0] sextet_to_char(input logic [5:0] sextet);
		logic [6:0] s7;
		s7 = {1'b0, sextet};
		if (sextet < SEXT_LOWER_START) begin
			return s7 + CHAR_UPPER_A;
		end else if (sextet < SEXT_DIGIT_START) begin
			return s7 + (CHAR_LOWER_A - {1'b0, SEXT_LOWER_START});
		end else if (sextet < SEXT_DASH) begin
			return s7 - ({1'b0, SEXT_DIGIT_START} - CHAR_DIGIT_0);
		end else if (sextet == SEXT_DASH) begin
			return CHAR_DASH;
		end else begin
			return CHAR_UNDERSCORE;
		end
	endfunction

endpackage

FILE: rtl/base64url_encoder_nopad.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64url_encoder_nopad
// URL-safe Base64 encoder without padding, one message byte per input word.
// ----------------------------------------------------------------------------
// A byte word is taken in any cycle in which the word queue has room, so bytes
// stream in at one per cycle; each byte yields one character, or two for the
// third byte of a group and for a final byte that leaves a partial sextet.
// Characters leave through a single output register at one per cycle while
// symbol_stall is low, so for long messages that register sets the sustained
// rate of four characters per three bytes. A character reaches symbol_valid
// through the word queue and then the output register. The
// queue of QUEUE_DEPTH words between the byte side and the character side
// absorbs output stalls; byte_stall rises only when it is full. last_symbol
// marks the closing character of a message, after which a new message starts.
// ----------------------------------------------------------------------------
module base64url_encoder_nopad
	import b64u_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	// byte side
	input  logic       byte_valid,
	output logic       byte_stall,
	input  logic [7:0] data_byte,
	input  logic       final_byte,
	// character side
	output logic       symbol_valid,
	input  logic       symbol_stall,
	output logic [6:0] symbol,
	output logic       last_symbol
);

	entry_t front_entry;
	entry_t q_head;
	logic   q_empty;
	logic   q_full;
	logic   q_pop;
	logic   take;

	// accept a byte whenever the queue can hold its word
	assign byte_stall = q_full;
	assign take       = byte_valid && !q_full;

	// front: phase tracking and sextet split
	b64u_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.data_byte (data_byte),
		.final_byte(final_byte),
		.entry     (front_entry)
	);

	// decoupling queue between byte and character sides
	b64u_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (take),
		.push_entry(front_entry),
		.pop       (q_pop),
		.head      (q_head),
		.empty     (q_empty),
		.full      (q_full)
	);

	// back: character mapping and output register
	b64u_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (q_head),
		.empty       (q_empty),
		.pop         (q_pop),
		.symbol      (symbol),
		.last_symbol (last_symbol),
		.symbol_valid(symbol_valid),
		.symbol_stall(symbol_stall)
	);

endmodule

FILE: rtl/b64u_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64u_front
// Accepts bytes, tracks the group phase and leftover bits, and splits each
// byte into the one or two sextets it completes.
// ----------------------------------------------------------------------------
module b64u_front
	import b64u_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,        // byte accepted this cycle
	input  logic [7:0] data_byte,
	input  logic       final_byte,
	output entry_t     entry
);

	group_phase_t phase_q, phase_d;
	logic [3:0]   carry_q, carry_d;

	always_comb begin
		entry.last = final_byte;
		case (phase_q)
			PH_SECOND: begin
				entry.sext_a = {carry_q[1:0], data_byte[7:4]};
				entry.sext_b = {data_byte[3:0], 2'b00};
				entry.pair   = final_byte;
				carry_d      = data_byte[3:0];
				phase_d      = PH_THIRD;
			end
			PH_THIRD: begin
				entry.sext_a = {carry_q[3:0], data_byte[7:6]};
				entry.sext_b = data_byte[5:0];
				entry.pair   = 1'b1;
				carry_d      = 4'd0;
				phase_d      = PH_FIRST;
			end
			default: begin
				entry.sext_a = data_byte[7:2];
				entry.sext_b = {data_byte[1:0], 4'b0000};
				entry.pair   = final_byte;
				carry_d      = {2'b00, data_byte[1:0]};
				phase_d      = PH_SECOND;
			end
		endcase
		if (final_byte) begin
			carry_d = 4'd0;
			phase_d = PH_FIRST;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FIRST;
			carry_q <= 4'd0;
		end else if (take) begin
			phase_q <= phase_d;
			carry_q <= carry_d;
		end
	end

endmodule

FILE: rtl/b64u_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64u_queue
// Small first-in first-out buffer of classified words between front and back.
// ----------------------------------------------------------------------------
module b64u_queue
	import b64u_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	input  logic   pop,
	output entry_t head,
	output logic   empty,
	output logic   full
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	entry_t             entries_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == CNT_W'(DEPTH));
	assign head  = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/b64u_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64u_back
// Drains classified words one character per cycle, while symbol_stall is low, into the output register.
// ----------------------------------------------------------------------------
module b64u_back
	import b64u_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  entry_t     head,
	input  logic       empty,
	output logic       pop,
	output logic [6:0] symbol,
	output logic       last_symbol,
	output logic       symbol_valid,
	input  logic       symbol_stall
);

	logic       valid_q;
	logic       second_q;     // first sextet of the head already sent
	logic [6:0] symbol_q;
	logic       last_q;
	logic       load;
	logic [5:0] sext_sel;
	logic       last_sel;

	assign load = !valid_q || !symbol_stall;
	assign pop  = load && !empty && (second_q || !head.pair);

	always_comb begin
		if (second_q) begin
			sext_sel = head.sext_b;
			last_sel = head.last;
		end else begin
			sext_sel = head.sext_a;
			last_sel = head.last && !head.pair;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			second_q <= 1'b0;
		end else if (load) begin
			valid_q <= !empty;
			if (!empty) begin
				second_q <= !second_q && head.pair;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && !empty) begin
			symbol_q <= sextet_to_char(sext_sel);
			last_q   <= last_sel;
		end
	end

	assign symbol       = symbol_q;
	assign last_symbol  = last_q;
	assign symbol_valid = valid_q;

endmodule

FILE: rtl/b64u_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64u_checker
// Port-level checks of the base64url encoder, bound to the top level.
// ----------------------------------------------------------------------------
module b64u_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       byte_valid,
	input logic       byte_stall,
	input logic [7:0] data_byte,
	input logic       final_byte,
	input logic       symbol_valid,
	input logic       symbol_stall,
	input logic [6:0] symbol,
	input logic       last_symbol
);

	logic       final_take;
	logic       last_give;
	logic [7:0] open_msgs_q;   // finals accepted whose last character is not out

	assign final_take = byte_valid && !byte_stall && final_byte;
	assign last_give  = symbol_valid && !symbol_stall && last_symbol;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_msgs_q <= '0;
		end else begin
			open_msgs_q <= open_msgs_q + {7'd0, final_take} - {7'd0, last_give};
		end
	end

	// stalled character holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		symbol_valid && symbol_stall |=>
			symbol_valid && $stable(symbol) && $stable(last_symbol))
		else $error("character changed while stalled");

	// only alphabet characters
	a_alphabet: assert property (@(posedge clk) disable iff (!arst_n)
		symbol_valid |->
			(symbol >= 7'h41 && symbol <= 7'h5A) || (symbol >= 7'h61 && symbol <= 7'h7A) ||
			(symbol >= 7'h30 && symbol <= 7'h39) || symbol == 7'h2D || symbol == 7'h5F)
		else $error("character outside base64url alphabet");

	// a closing character needs a final byte taken earlier
	a_last_follows_final: assert property (@(posedge clk) disable iff (!arst_n)
		last_give |-> open_msgs_q != 8'd0)
		else $error("last character without a final byte");

	// no character right out of reset
	a_quiet_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !symbol_valid)
		else $error("character valid right after reset");

endmodule

bind base64url_encoder_nopad b64u_checker u_checker (.*);

FILE: tb/sv/tb_base64url_encoder_nopad.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_base64url_encoder_nopad
// Self-checking bench for the base64url encoder without padding.
// ----------------------------------------------------------------------------
// Byte words go in one at a time, and each message ends on a word with
// final_byte set. A scoreboard tracks the group position and the leftover
// bits of the current group. From every accepted byte it predicts the
// characters that byte must produce. Each character that comes out is
// checked in order against the oldest prediction. Both sides idle and stall
// at random. The run also has a quiet stretch with no idling, a long hold-off
// on the character side that fills the block, and a pause on the byte side
// that lets the block drain.
// ----------------------------------------------------------------------------
module tb_base64url_encoder_nopad;
	import b64u_pkg::*;

	localparam int    CLK_PERIOD  = 4;
	localparam int    RESET_CYCLES = 8;
	localparam int    IDLE_PCT    = 29;
	localparam int    HOLD_CYCLES = 150;
	localparam int    QUIET_LIMIT = 2000;  // cycles with no handshake at all
	localparam int    TAIL_CYCLES = 20;
	localparam string URL_ALPHABET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";

	// directed messages, bit 8 flags the closing byte of a message
	localparam logic [8:0] DIRECTED_WORDS [19] = '{
		9'h100,                          // single zero byte
		9'h1FF,                          // single all-ones byte
		9'h0FB, 9'h1EF,                  // two bytes, first char is '-'
		9'h0FF, 9'h0FF, 9'h1FF,          // full group, all '_'
		9'h000, 9'h000, 9'h000, 9'h100,  // full group plus a lone byte
		9'h0AA, 9'h055, 9'h0A5, 9'h05A, 9'h10F,  // group plus two-byte tail
		9'h0F8, 9'h03E, 9'h1FB           // ends on the third byte of a group
	};

	// one expected character
	typedef struct packed {
		logic [6:0] code;
		logic       last;
	} char_word_t;

	// predicts the character stream and checks what comes out
	class symbol_scoreboard;
		char_word_t   pending_chars[$];
		group_phase_t phase;
		logic [3:0]   carry;
		int           errors;

		function new();
			phase  = PH_FIRST;
			carry  = 4'h0;
			errors = 0;
		endfunction

		function void push_sextet(logic [5:0] sextet, logic last);
			char_word_t w;
			w.code = 7'(URL_ALPHABET[sextet]);
			w.last = last;
			pending_chars.push_back(w);
		endfunction

		// one accepted byte word
		function void note_byte(logic [7:0] b, logic fin);
			case (phase)
				PH_SECOND: begin
					push_sextet({carry[1:0], b[7:4]}, 1'b0);
					carry = b[3:0];
					phase = PH_THIRD;
					if (fin)
						push_sextet({carry, 2'b00}, 1'b1);
				end
				PH_THIRD: begin
					push_sextet({carry, b[7:6]}, 1'b0);
					push_sextet(b[5:0], fin);
					carry = 4'h0;
					phase = PH_FIRST;
				end
				default: begin
					push_sextet(b[7:2], 1'b0);
					carry = {2'b00, b[1:0]};
					phase = PH_SECOND;
					if (fin)
						push_sextet({carry[1:0], 4'b0000}, 1'b1);
				end
			endcase
			if (fin) begin
				phase = PH_FIRST;
				carry = 4'h0;
			end
		endfunction

		// one accepted character word
		function void check_symbol(logic [6:0] code, logic last);
			char_word_t w;
			if (pending_chars.size() == 0) begin
				$error("unexpected character word: symbol %0h last_symbol %0b", code, last);
				errors++;
				return;
			end
			w = pending_chars.pop_front();
			if (code !== w.code) begin
				$error("symbol mismatch: expected %0h, actual %0h", w.code, code);
				errors++;
			end
			if (last !== w.last) begin
				$error("last_symbol mismatch: expected %0b, actual %0b", w.last, last);
				errors++;
			end
		endfunction

		function int pending();
			return pending_chars.size();
		endfunction
	endclass

	logic       clk;
	logic       arst_n       = 1'b0;
	logic       byte_valid   = 1'b0;
	logic       byte_stall;
	logic [7:0] data_byte    = 8'h00;
	logic       final_byte   = 1'b0;
	logic       symbol_valid;
	logic       symbol_stall = 1'b0;
	logic [6:0] symbol;
	logic       last_symbol;

	symbol_scoreboard sb = new();

	// knobs shared between the stimulus and the receiver
	bit src_idle_on  = 1'b1;
	bit sink_idle_on = 1'b1;
	int hold_request = 0;
	int quiet_cycles = 0;

	base64url_encoder_nopad DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_valid  (byte_valid),
		.byte_stall  (byte_stall),
		.data_byte   (data_byte),
		.final_byte  (final_byte),
		.symbol_valid(symbol_valid),
		.symbol_stall(symbol_stall),
		.symbol      (symbol),
		.last_symbol (last_symbol)
	);

	always begin
		clk = 1'b0;
		#(CLK_PERIOD / 2);
		clk = 1'b1;
		#(CLK_PERIOD / 2);
	end

	// monitor: both handshakes are sampled on the rising edge, before the
	// block's own registers update, so the pre-edge values decide acceptance
	always @(posedge clk) begin
		if (arst_n) begin
			// check first so a character can never match a byte of the same edge
			if (symbol_valid && !symbol_stall)
				sb.check_symbol(symbol, last_symbol);
			if (byte_valid && !byte_stall)
				sb.note_byte(data_byte, final_byte);
			if ((symbol_valid && !symbol_stall) || (byte_valid && !byte_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
	end

	// receiver: stall is driven on the falling edge; a hold-off request
	// is taken over here and counted down in this process
	always @(negedge clk) begin
		int hold_left;
		if (hold_request > 0) begin
			hold_left    = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			symbol_stall <= 1'b1;
			hold_left--;
		end else begin
			symbol_stall <= sink_idle_on && ($urandom_range(99) < IDLE_PCT);
		end
	end

	// watchdog: a stuck block stops all handshakes
	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("== FAIL ==");
		$finish;
	end

	// offer one byte word and hold it until it is taken; returns on the
	// accepting rising edge, so the next word goes out on the falling edge
	task automatic send_byte(input logic [7:0] b, input logic fin);
		@(negedge clk);
		while (src_idle_on && ($urandom_range(99) < IDLE_PCT)) begin
			byte_valid <= 1'b0;
			@(negedge clk);
		end
		byte_valid <= 1'b1;
		data_byte  <= b;
		final_byte <= fin;
		do
			@(posedge clk);
		while (byte_stall);
	endtask

	// stop offering and wait until every predicted character has come out
	task automatic wait_drained();
		@(negedge clk);
		byte_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// random messages, mostly short ones with the odd long one,
	// until at least byte_budget bytes have gone in
	task automatic send_messages(input int byte_budget);
		int sent;
		int len;
		sent = 0;
		while (sent < byte_budget) begin
			if ($urandom_range(9) == 0)
				len = $urandom_range(40, 10);
			else
				len = $urandom_range(9, 1);
			for (int i = 0; i < len; i++)
				send_byte(8'($urandom_range(255)), i == len - 1);
			sent += len;
		end
	endtask

	initial begin
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		// directed: field extremes, '-' and '_', every group position as the
		// final byte, a message continued right after a final byte
		foreach (DIRECTED_WORDS[i])
			send_byte(DIRECTED_WORDS[i][7:0], DIRECTED_WORDS[i][8]);

		send_messages(400);

		// quiet stretch: full rate on both sides
		src_idle_on  = 1'b0;
		sink_idle_on = 1'b0;
		send_messages(300);
		sink_idle_on = 1'b1;

		// long hold-off on the character side while bytes keep coming,
		// so the word queue fills and the byte side stalls
		hold_request = HOLD_CYCLES;
		send_messages(40);
		src_idle_on = 1'b1;

		// byte side pauses until everything has come out
		wait_drained();

		send_messages(800);

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (sb.errors == 0 && sb.pending() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
